/* hdl/rrwl_pkg.sv */
package rrwl_pkg;

	// sizing
	localparam int MAX_REQUESTERS = 16;
	localparam int MAX_READERS    = 8;
	localparam int COUNT_BITS     = 16;

	localparam int ID_W      = 4;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int ENTRIES_W = 4;
	localparam int IDX_W     = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
	localparam int USED_W    = $clog2(MAX_READERS + 1);

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [ID_W-1:0]       id_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [USED_W-1:0]     used_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENTER_READ  = 2'd0,
		CMD_LEAVE_READ  = 2'd1,
		CMD_ENTER_WRITE = 2'd2,
		CMD_LEAVE_WRITE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_WAIT       = 2'd1,
		ST_NOT_HOLDER = 2'd2,
		ST_NO_ROOM    = 2'd3
	} status_t;

	// one reader table entry
	typedef struct packed {
		id_t  id;
		cnt_t cnt;
	} entry_t;

	// table write port
	typedef struct packed {
		logic   en;
		idx_t   idx;
		entry_t data;
	} tbl_wr_t;

	// shared count unit result
	typedef struct packed {
		cnt_t value;
		logic at_max;
		logic above_one;
	} unit_res_t;

	// result of one request
	typedef struct packed {
		status_t                status;
		logic                   writer_held;
		logic [ENTRIES_W-1:0]   reader_entries;
	} result_t;

endpackage

/* hdl/reentrant_reader_writer_lock_core.sv */
// Steps from input beat to result beat: a reader table scan over the entries looked at,
//   a decide step, table compaction on a last leave read, the output register, then out.
// One request at a time: the next beat is taken only once the sequencer is back in idle,
//   after the scan and compaction through one table read port and one count unit.
// Reset (arst_n, asynchronous): no readers, no writer, no waiting writers, output empty.
module reentrant_reader_writer_lock_core import rrwl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// request stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [1:0] command, [5:2] requester, [7:6] zero
	// response stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [1:0] status, [2] writer_held, [6:3] reader_entries,
	                              // [7] zero
);

	// Request decode. The command field covers all four codes.
	cmd_t    in_cmd;
	id_t     in_id;
	logic    res_valid;
	logic    res_ready;
	result_t res;

	// Output register: one beat of slack, so the sequencer can finish and
	// return to idle while a response still waits downstream.
	logic    m_tvalid_q;
	result_t m_res_q;

	assign in_cmd = cmd_t'(s_tdata[1:0]);
	assign in_id  = s_tdata[5:2];

	rrwl_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (in_cmd),
		.in_id     (in_id),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// take a new response when the register is empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_res_q.reader_entries, m_res_q.writer_held, m_res_q.status};

endmodule

/* hdl/rrwl_table.sv */
module rrwl_table #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	// no reset: entries at or above the fill count are never used
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/rrwl_unit.sv */
module rrwl_unit import rrwl_pkg::*; (
	input  cnt_t      operand,
	input  logic      dec,
	output unit_res_t res
);

	// one incrementer/decrementer shared by reader counts and writer depth
	always_comb begin
		res.value     = dec ? (operand - cnt_t'(1)) : (operand + cnt_t'(1));
		res.at_max    = (operand == '1);
		res.above_one = (operand > cnt_t'(1));
	end

endmodule

/* hdl/rrwl_seq.sv */
module rrwl_seq import rrwl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  cmd_t    in_cmd,
	input  id_t     in_id,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                    state_q;
	cmd_t                      cmd_q;
	id_t                       id_q;
	used_t                     idx_q;
	used_t                     k_q;
	idx_t                      pos_q;
	logic                      found_q;
	cnt_t                      cnt_q;
	status_t                   st_q;
	used_t                     used_q;
	id_t                       owner_q;
	cnt_t                      depth_q;
	logic [MAX_REQUESTERS-1:0] map_q;

	used_t     k_nxt;
	used_t     rd_ptr;
	idx_t      rd_idx;
	entry_t    rd;
	tbl_wr_t   wr;
	cnt_t      operand;
	logic      dec;
	unit_res_t unit;

	status_t st_d;
	logic    used_inc;
	logic    go_shift;
	logic    map_set;
	logic    map_clr;
	logic    depth_upd;
	logic    owner_clr;
	logic    is_writer;
	logic    no_writer;
	logic    id_ok;

	assign k_nxt = k_q + used_t'(1);

	// table read is registered: the address goes out in the cycle before the entry is needed
	always_comb begin
		unique case (state_q)
			S_SCAN:   rd_ptr = idx_q + used_t'(1);
			S_DECIDE: rd_ptr = used_t'(pos_q) + used_t'(1);
			S_SHIFT:  rd_ptr = k_q + used_t'(2);
			default:  rd_ptr = '0;
		endcase
	end

	assign rd_idx = rd_ptr[IDX_W-1:0];

	rrwl_table #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_READERS)
	) u_table (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.raddr (rd_idx),
		.rdata (rd)
	);

	// write commands work on the depth, read commands on the found count
	assign operand = (cmd_q == CMD_ENTER_WRITE || cmd_q == CMD_LEAVE_WRITE) ? depth_q : cnt_q;
	assign dec     = (cmd_q == CMD_LEAVE_READ || cmd_q == CMD_LEAVE_WRITE);

	rrwl_unit u_unit (
		.operand (operand),
		.dec     (dec),
		.res     (unit)
	);

	assign no_writer = (depth_q == '0);
	assign is_writer = !no_writer && (owner_q == id_q);
	assign id_ok     = (32'(id_q) < MAX_REQUESTERS);

	always_comb begin
		wr          = '0;
		wr.idx      = pos_q;
		wr.data.id  = id_q;
		wr.data.cnt = unit.value;
		st_d        = ST_OK;
		used_inc    = 1'b0;
		go_shift    = 1'b0;
		map_set     = 1'b0;
		map_clr     = 1'b0;
		depth_upd   = 1'b0;
		owner_clr   = 1'b0;
		if (state_q == S_DECIDE) begin
			unique case (cmd_q)
				CMD_ENTER_READ: begin
					if (!(found_q || (no_writer && map_q == '0) || is_writer)) begin
						st_d = ST_WAIT;
					end else if (found_q) begin
						if (unit.at_max) st_d = ST_NO_ROOM;
						else wr.en = 1'b1;
					end else if (used_q >= used_t'(MAX_READERS)) begin
						st_d = ST_NO_ROOM;
					end else begin
						wr.en       = 1'b1;
						wr.idx      = used_q[IDX_W-1:0];
						wr.data.cnt = cnt_t'(1);
						used_inc    = 1'b1;
					end
				end
				CMD_LEAVE_READ: begin
					if (!found_q) st_d = ST_NOT_HOLDER;
					else if (unit.above_one) wr.en = 1'b1;
					else go_shift = 1'b1;
				end
				CMD_ENTER_WRITE: begin
					if (!((used_q == '0 && no_writer) || is_writer ||
					      (no_writer && used_q == used_t'(1) && found_q))) begin
						st_d    = ST_WAIT;
						map_set = 1'b1;
					end else if (unit.at_max) begin
						st_d = ST_NO_ROOM;
					end else begin
						depth_upd = 1'b1;
						map_clr   = 1'b1;
					end
				end
				CMD_LEAVE_WRITE: begin
					if (!is_writer) begin
						st_d = ST_NOT_HOLDER;
					end else begin
						depth_upd = 1'b1;
						owner_clr = !unit.above_one;
					end
				end
				default: st_d = ST_OK;
			endcase
		end else if (state_q == S_SHIFT && k_nxt < used_q) begin
			// move the next entry down one place
			wr.en   = 1'b1;
			wr.idx  = k_q[IDX_W-1:0];
			wr.data = rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			owner_q <= '0;
			depth_q <= '0;
			map_q   <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
			k_q     <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			st_q    <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q >= used_q) begin
						state_q <= S_DECIDE;
					end else if (rd.id == id_q) begin
						found_q <= 1'b1;
						pos_q   <= idx_q[IDX_W-1:0];
						cnt_q   <= rd.cnt;
						state_q <= S_DECIDE;
					end else begin
						idx_q <= idx_q + used_t'(1);
					end
				end
				S_DECIDE: begin
					st_q <= st_d;
					if (used_inc) used_q <= used_q + used_t'(1);
					if (map_set && id_ok) map_q[id_q] <= 1'b1;
					if (map_clr && id_ok) map_q[id_q] <= 1'b0;
					if (depth_upd) begin
						depth_q <= unit.value;
						owner_q <= owner_clr ? id_t'(0) : id_q;
					end
					if (go_shift) begin
						k_q     <= {{(USED_W-IDX_W){1'b0}}, pos_q};
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (k_nxt < used_q) begin
						k_q <= k_nxt;
					end else begin
						used_q  <= used_q - used_t'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload needs no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= in_cmd;
			id_q  <= in_id;
		end
	end

	assign in_ready           = (state_q == S_IDLE);
	assign res_valid          = (state_q == S_DONE);
	assign res.status         = st_q;
	assign res.writer_held    = !no_writer;
	assign res.reader_entries = ENTRIES_W'(used_q);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench import rrwl_pkg::*;;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	reentrant_reader_writer_lock_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the lock state, advanced as each request beat is accepted
	id_t                       rd_id  [MAX_READERS];
	cnt_t                      rd_cnt [MAX_READERS];
	int                        rd_used = 0;
	id_t                       wr_owner = '0;
	cnt_t                      wr_depth = '0;
	logic [MAX_REQUESTERS-1:0] wr_waiting = '0;

	result_t lock_replies_due [$];
	int      mismatches = 0;
	bit      calm = 1'b0;          // no idling on either side
	bit      hold_request = 1'b0;  // ask the receiver for one long hold-off

	// directed rows; typed rows carry their answer, the rest use the predictor
	typedef struct packed {
		cmd_t       cmd;
		id_t        who;
		bit         typed;
		status_t    st;
		logic       held;
		logic [3:0] ent;
	} row_t;

	row_t script [0:28] = '{
		'{CMD_ENTER_READ,  4'd0,  1'b1, ST_OK,         1'b0, 4'd1},
		'{CMD_LEAVE_READ,  4'd0,  1'b1, ST_OK,         1'b0, 4'd0},
		'{CMD_LEAVE_READ,  4'd5,  1'b1, ST_NOT_HOLDER, 1'b0, 4'd0},
		'{CMD_LEAVE_WRITE, 4'd15, 1'b1, ST_NOT_HOLDER, 1'b0, 4'd0},
		'{CMD_ENTER_WRITE, 4'd15, 1'b1, ST_OK,         1'b1, 4'd0},
		'{CMD_ENTER_WRITE, 4'd15, 1'b1, ST_OK,         1'b1, 4'd0},
		// writer may also read
		'{CMD_ENTER_READ,  4'd15, 1'b1, ST_OK,         1'b1, 4'd1},
		'{CMD_ENTER_READ,  4'd3,  1'b1, ST_WAIT,       1'b1, 4'd1},
		// refused writer gets marked as waiting
		'{CMD_ENTER_WRITE, 4'd3,  1'b1, ST_WAIT,       1'b1, 4'd1},
		'{CMD_LEAVE_WRITE, 4'd15, 1'b1, ST_OK,         1'b1, 4'd1},
		'{CMD_LEAVE_WRITE, 4'd15, 1'b1, ST_OK,         1'b0, 4'd1},
		// new reader held off by the waiting writer, existing one not
		'{CMD_ENTER_READ,  4'd7,  1'b0, ST_OK,         1'b0, 4'd0},
		'{CMD_ENTER_READ,  4'd15, 1'b0, ST_OK,         1'b0, 4'd0},
		// sole reader upgrades to writer
		'{CMD_ENTER_WRITE, 4'd15, 1'b0, ST_OK,         1'b0, 4'd0},
		'{CMD_LEAVE_WRITE, 4'd15, 1'b0, ST_OK,         1'b0, 4'd0},
		'{CMD_LEAVE_READ,  4'd15, 1'b0, ST_OK,         1'b0, 4'd0},
		'{CMD_LEAVE_READ,  4'd15, 1'b0, ST_OK,         1'b0, 4'd0},
		'{CMD_ENTER_WRITE, 4'd3,  1'b0, ST_OK,         1'b0, 4'd0},
		'{CMD_LEAVE_WRITE, 4'd3,  1'b1, ST_OK,         1'b0, 4'd0},
		// fill the reader table, then one too many
		'{CMD_ENTER_READ,  4'd0,  1'b1, ST_OK,         1'b0, 4'd1},
		'{CMD_ENTER_READ,  4'd1,  1'b1, ST_OK,         1'b0, 4'd2},
		'{CMD_ENTER_READ,  4'd2,  1'b1, ST_OK,         1'b0, 4'd3},
		'{CMD_ENTER_READ,  4'd3,  1'b1, ST_OK,         1'b0, 4'd4},
		'{CMD_ENTER_READ,  4'd4,  1'b1, ST_OK,         1'b0, 4'd5},
		'{CMD_ENTER_READ,  4'd5,  1'b1, ST_OK,         1'b0, 4'd6},
		'{CMD_ENTER_READ,  4'd6,  1'b1, ST_OK,         1'b0, 4'd7},
		'{CMD_ENTER_READ,  4'd7,  1'b1, ST_OK,         1'b0, 4'd8},
		'{CMD_ENTER_READ,  4'd8,  1'b1, ST_NO_ROOM,    1'b0, 4'd8},
		// middle entry leaves, later ones move down
		'{CMD_LEAVE_READ,  4'd3,  1'b0, ST_OK,         1'b0, 4'd0}
	};

	function automatic result_t predict_lock(cmd_t cmd, id_t who);
		result_t r;
		status_t st;
		int      slot;
		int      i;
		logic    present;
		logic    owns;
		slot = rd_used;
		for (i = rd_used - 1; i >= 0; i--)
			if (rd_id[i] == who)
				slot = i;
		present = slot < rd_used;
		owns = (wr_depth != 0) && (wr_owner == who);
		st = ST_OK;
		unique case (cmd)
			CMD_ENTER_READ: begin
				if (!(present || (wr_depth == 0 && wr_waiting == '0) || owns))
					st = ST_WAIT;
				else if (present) begin
					if (rd_cnt[slot] == '1)
						st = ST_NO_ROOM;
					else
						rd_cnt[slot]++;
				end else if (rd_used >= MAX_READERS)
					st = ST_NO_ROOM;
				else begin
					rd_id[rd_used] = who;
					rd_cnt[rd_used] = cnt_t'(1);
					rd_used++;
				end
			end
			CMD_LEAVE_READ: begin
				if (!present)
					st = ST_NOT_HOLDER;
				else if (rd_cnt[slot] > 1)
					rd_cnt[slot]--;
				else begin
					for (i = slot; i + 1 < rd_used; i++) begin
						rd_id[i] = rd_id[i + 1];
						rd_cnt[i] = rd_cnt[i + 1];
					end
					rd_used--;
				end
			end
			CMD_ENTER_WRITE: begin
				if (!((rd_used == 0 && wr_depth == 0) || owns ||
				      (wr_depth == 0 && rd_used == 1 && rd_id[0] == who))) begin
					wr_waiting[who] = 1'b1;
					st = ST_WAIT;
				end else if (wr_depth == '1)
					st = ST_NO_ROOM;
				else begin
					wr_owner = who;
					wr_depth++;
					wr_waiting[who] = 1'b0;
				end
			end
			default: begin
				if (!owns)
					st = ST_NOT_HOLDER;
				else begin
					wr_depth--;
					if (wr_depth == 0)
						wr_owner = '0;
				end
			end
		endcase
		r.status = st;
		r.writer_held = wr_depth != 0;
		r.reader_entries = rd_used[3:0];
		return r;
	endfunction

	// offer one request beat and log its answer once it is taken
	task automatic issue(input cmd_t cmd, input id_t who, input bit typed,
	                     input result_t want);
		result_t model;
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, who, cmd};
		do @(posedge clk); while (s_tready !== 1'b1);
		model = predict_lock(cmd, who);
		lock_replies_due.push_back(typed ? want : model);
	endtask

	task automatic pace();
		if (!calm && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// mostly sensible traffic: holders leave, waiting writers retry
	task automatic pick_request(output cmd_t cmd, output id_t who);
		int roll;
		int k;
		roll = $urandom_range(0, 99);
		cmd = cmd_t'($urandom_range(0, 3));
		who = id_t'($urandom_range(0, 15));
		if (roll >= 25) begin
			if (roll < 45 && rd_used > 0) begin
				cmd = CMD_LEAVE_READ;
				who = rd_id[$urandom_range(0, rd_used - 1)];
			end else if (roll < 55 && wr_depth != 0) begin
				cmd = CMD_LEAVE_WRITE;
				who = wr_owner;
			end else if (roll < 72) begin
				cmd = CMD_ENTER_WRITE;
				if (wr_waiting != '0 && $urandom_range(0, 1) == 1) begin
					k = $urandom_range(0, MAX_REQUESTERS - 1);
					while (!wr_waiting[k])
						k = (k + 1) % MAX_REQUESTERS;
					who = id_t'(k);
				end else if (wr_depth != 0 && $urandom_range(0, 2) == 0)
					who = wr_owner;
			end else begin
				cmd = CMD_ENTER_READ;
				if (rd_used > 0 && $urandom_range(0, 2) == 0)
					who = rd_id[$urandom_range(0, rd_used - 1)];
			end
		end
	endtask

	initial begin : stimulus
		cmd_t    cmd;
		id_t     who;
		result_t want;
		int      n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			want.status = script[i].st;
			want.writer_held = script[i].held;
			want.reader_entries = script[i].ent;
			issue(script[i].cmd, script[i].who, script[i].typed, want);
			pace();
		end

		want = '0;
		for (n = 0; n < 1900; n++) begin
			if (n == 700)
				hold_request = 1'b1;
			if (n == 1500)
				calm = 1'b1;
			pick_request(cmd, who);
			issue(cmd, who, 1'b0, want);
			pace();
		end

		// release everything, then one stray leave write
		while (wr_depth != 0)
			issue(CMD_LEAVE_WRITE, wr_owner, 1'b0, want);
		while (rd_used != 0)
			issue(CMD_LEAVE_READ, rd_id[0], 1'b0, want);
		issue(CMD_LEAVE_WRITE, 4'd9, 1'b0, want);
		s_tvalid <= 1'b0;

		while (lock_replies_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && lock_replies_due.size() == 0)
			$display("reentrant_reader_writer_lock_core regression: pass");
		else
			$display("reentrant_reader_writer_lock_core regression: fail");
		$finish;
	end

	// response side: random hold-offs, one long one, none once calm
	initial begin : receiver
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_replies
		result_t want;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (lock_replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response beat %h", m_tdata);
			end else begin
				want = lock_replies_due.pop_front();
				if (m_tdata[1:0] !== want.status || m_tdata[2] !== want.writer_held ||
				    m_tdata[6:3] !== want.reader_entries) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: got st %0d held %0d ent %0d, want st %0d held %0d ent %0d",
						         m_tdata[1:0], m_tdata[2], m_tdata[6:3],
						         want.status, want.writer_held, want.reader_entries);
				end
			end
		end
	end

	initial begin : watchdog
		#50_000_000;
		$display("reentrant_reader_writer_lock_core regression: fail");
		$finish;
	end

endmodule
